// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge out of reset
`define CRC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// checked on every rising edge, reset included
`define CRC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// File: sv/crc_pkg.sv
// ----------------------------------------------------------------------------
// crc_pkg
// shared constants and types of the coverage ratio classifier
// ----------------------------------------------------------------------------
package crc_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] HELD_MAX = CNT_W'(TABLE_DEPTH);

    localparam int COORD_W = 31;
    localparam int COUNT_W = 32;
    localparam int SCORE_W = 32;
    localparam int ENTRY_W = 2 * COORD_W + COUNT_W;
    localparam int TH_W    = 16;
    localparam int FLANK_W = 10;
    localparam int RATIO_W = 24;
    localparam int NUM_W   = 59;
    localparam int DEN_W   = 64;
    localparam int QCNT_W  = $clog2(NUM_W + 1);

    localparam int IN_W  = 192;
    localparam int OUT_W = 120;

    localparam logic [RATIO_W-1:0] RATIO_MAX = '1;
    localparam logic [TH_W-1:0]    TH_RESET    = 16'd1638;
    localparam logic [FLANK_W-1:0] FLANK_RESET = 10'd20;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_IGNORE = 2'd3;

    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_FLANK     = 1'b1;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SCAN  = 7'b0000010,
        ST_MUL1  = 7'b0000100,
        ST_MUL2  = 7'b0001000,
        ST_DIVGO = 7'b0010000,
        ST_DIVW  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    typedef enum logic [2:0] {
        LK_DEL   = 3'b001,
        LK_LEFT  = 3'b010,
        LK_RIGHT = 3'b100
    } lk_sel_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// File: sv/crc_div.sv
// ----------------------------------------------------------------------------
// crc_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crc_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [crc_pkg::NUM_W-1:0]     dividend,
    input  logic [crc_pkg::DEN_W-1:0]     divisor,
    output crc_pkg::div_stat_t            stat,
    output logic [crc_pkg::NUM_W-1:0]     quotient
);

    logic [crc_pkg::DEN_W-1:0]  rem_reg, rem_next;
    logic [crc_pkg::NUM_W-1:0]  quo_reg, quo_next;
    logic [crc_pkg::DEN_W-1:0]  den_reg, den_next;
    logic [crc_pkg::QCNT_W-1:0] cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [crc_pkg::DEN_W:0]    trial;
    logic                       take;

    always_comb begin
        trial     = {rem_reg, quo_reg[crc_pkg::NUM_W-1]};
        take      = (trial >= {1'b0, den_reg});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start && !busy_reg) begin
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
            cnt_next  = crc_pkg::QCNT_W'(crc_pkg::NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = take ? crc_pkg::DEN_W'(trial - {1'b0, den_reg})
                            : trial[crc_pkg::DEN_W-1:0];
            quo_next = {quo_reg[crc_pkg::NUM_W-2:0], take};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == crc_pkg::QCNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

    `CRC_ASSERT(a_div_no_restart, aclk, aresetn, busy_reg |-> !start)
    `CRC_ASSERT(a_div_done_ends, aclk, aresetn, done_reg |-> $past(busy_reg) && !busy_reg)
    `CRC_ASSERT(a_div_start_busy, aclk, aresetn, (start && !busy_reg) |=> busy_reg)

endmodule

// File: sv/coverage_ratio_classifier.sv
// ----------------------------------------------------------------------------
// coverage_ratio_classifier
// coverage table with interval lookups and a q8.16 ratio band classifier
// ----------------------------------------------------------------------------
// Clear and append words complete without leaving the idle state. A query
// walks the table up to three times through its single read port, one entry
// per cycle; a miss ends the query early. One shared multiplier then forms
// the two products and the bit-serial divider the ratio. The input is not
// ready while a query is in progress; a finished result waits in the output
// register while the next word is taken.
`include "assert_macros.svh"

module coverage_ratio_classifier (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [crc_pkg::TH_W-1:0]    cfg_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // entry_start, entry_end, entry_count, query_start, query_end, query_score
    input  logic [crc_pkg::IN_W-1:0]    s_tdata,
    // command
    input  logic [1:0]                  s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // keep, not_found, ratio, result_start, result_end, result_score
    output logic [crc_pkg::OUT_W-1:0]   m_tdata
);

    localparam int CW = crc_pkg::COORD_W;

    logic [crc_pkg::ENTRY_W-1:0] mem [crc_pkg::TABLE_DEPTH];

    crc_pkg::state_t  state_reg, state_next;
    crc_pkg::lk_sel_t sel_reg, sel_next;

    logic [crc_pkg::TH_W-1:0]    th_reg;
    logic [crc_pkg::FLANK_W-1:0] f_reg;
    logic [crc_pkg::CNT_W-1:0]   held_reg, held_next;
    logic [crc_pkg::CNT_W-1:0]   issue_reg, issue_next;
    logic                        pend_reg, pend_next;
    logic                        run_reg, run_next;
    logic [crc_pkg::ENTRY_W-1:0] rd_reg;
    logic [CW-1:0]               key_s_reg, key_s_next;
    logic [CW:0]                 key_e_reg, key_e_next;
    logic [CW-1:0]               qs_reg, qs_next, qe_reg, qe_next;
    logic [crc_pkg::SCORE_W-1:0] sc_reg, sc_next;
    logic [crc_pkg::COUNT_W-1:0] del_reg, del_next, left_reg, left_next;
    logic [crc_pkg::COUNT_W-1:0] right_reg, right_next;
    logic [crc_pkg::DEN_W-1:0]   prod_reg, prod_next;
    logic [crc_pkg::NUM_W-1:0]   num_reg, num_next;
    logic                        keep_reg, keep_next, nf_reg, nf_next;
    logic [crc_pkg::RATIO_W-1:0] ratio_reg, ratio_next;
    logic                        m_valid_reg, m_valid_next;
    logic [crc_pkg::OUT_W-1:0]   m_data_reg, m_data_next;

    logic                        accept, wr_en, div_start;
    logic [CW-1:0]               rd_start, rd_end;
    logic [crc_pkg::COUNT_W-1:0] rd_count;
    logic                        match_s, match_e, hit, miss, issue_more;
    logic [32:0]                 mul_a, sum;
    logic [31:0]                 mul_b;
    logic [64:0]                 product;
    logic [crc_pkg::RATIO_W-1:0] r_q;
    logic [24:0]                 rz, thz;
    crc_pkg::div_stat_t          div_stat;
    logic [crc_pkg::NUM_W-1:0]   quotient;

    assign s_tready = (state_reg == crc_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign wr_en    = accept && (s_tuser == crc_pkg::CMD_APPEND)
                      && (held_reg < crc_pkg::HELD_MAX);

    assign rd_start = rd_reg[CW-1:0];
    assign rd_end   = rd_reg[2*CW-1:CW];
    assign rd_count = rd_reg[crc_pkg::ENTRY_W-1:2*CW];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[held_reg[crc_pkg::IDX_W-1:0]] <= s_tdata[crc_pkg::ENTRY_W-1:0];
        end
        rd_reg <= mem[issue_reg[crc_pkg::IDX_W-1:0]];
    end

    assign issue_more = (issue_reg < held_reg);
    assign match_s    = (rd_start == key_s_reg);
    assign match_e    = ({1'b0, rd_end} == key_e_reg);
    assign hit        = pend_reg && match_s && match_e;
    assign miss       = (pend_reg && run_reg && !match_s) || (!pend_reg && !issue_more);

    assign sum     = {1'b0, left_reg} + {1'b0, right_reg};
    assign product = mul_a * mul_b;

    always_comb begin
        if (state_reg == crc_pkg::ST_MUL2) begin
            mul_a = sum;
            mul_b = {1'b0, qe_reg - qs_reg};
        end else begin
            mul_a = {1'b0, del_reg};
            mul_b = {21'd0, f_reg, 1'b0};
        end
    end

    assign r_q = (|quotient[crc_pkg::NUM_W-1:crc_pkg::RATIO_W]) ? crc_pkg::RATIO_MAX
                 : quotient[crc_pkg::RATIO_W-1:0];
    assign rz  = {1'b0, r_q};
    assign thz = 25'(th_reg);

    always_comb begin
        state_next   = state_reg;
        sel_next     = sel_reg;
        held_next    = held_reg;
        issue_next   = issue_reg;
        pend_next    = 1'b0;
        run_next     = run_reg;
        key_s_next   = key_s_reg;
        key_e_next   = key_e_reg;
        qs_next      = qs_reg;
        qe_next      = qe_reg;
        sc_next      = sc_reg;
        del_next     = del_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        prod_next    = prod_reg;
        num_next     = num_reg;
        keep_next    = keep_reg;
        nf_next      = nf_reg;
        ratio_next   = ratio_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        div_start    = 1'b0;

        unique case (state_reg)
            crc_pkg::ST_IDLE: begin
                if (accept) begin
                    case (s_tuser)
                        crc_pkg::CMD_CLEAR:  held_next = '0;
                        crc_pkg::CMD_APPEND: if (wr_en) held_next = held_reg + 1'b1;
                        crc_pkg::CMD_QUERY: begin
                            qs_next    = s_tdata[124:94];
                            qe_next    = s_tdata[155:125];
                            sc_next    = s_tdata[187:156];
                            key_s_next = s_tdata[124:94];
                            key_e_next = {1'b0, s_tdata[155:125]};
                            sel_next   = crc_pkg::LK_DEL;
                            issue_next = '0;
                            run_next   = 1'b0;
                            keep_next  = 1'b0;
                            nf_next    = 1'b0;
                            ratio_next = '0;
                            state_next = crc_pkg::ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            crc_pkg::ST_SCAN: begin
                if (issue_more) begin
                    issue_next = issue_reg + 1'b1;
                    pend_next  = 1'b1;
                end
                if (pend_reg && match_s) begin
                    run_next = 1'b1;
                end
                if (hit) begin
                    issue_next = '0;
                    pend_next  = 1'b0;
                    run_next   = 1'b0;
                    unique case (sel_reg)
                        crc_pkg::LK_DEL: begin
                            del_next = rd_count;
                            if (qs_reg >= CW'(f_reg)) begin
                                key_s_next = qs_reg - CW'(f_reg);
                                key_e_next = {1'b0, qs_reg};
                                sel_next   = crc_pkg::LK_LEFT;
                            end else begin
                                nf_next    = 1'b1;
                                state_next = crc_pkg::ST_OUT;
                            end
                        end
                        crc_pkg::LK_LEFT: begin
                            left_next  = rd_count;
                            key_s_next = qe_reg;
                            key_e_next = {1'b0, qe_reg} + (CW+1)'(f_reg);
                            sel_next   = crc_pkg::LK_RIGHT;
                        end
                        crc_pkg::LK_RIGHT: begin
                            right_next = rd_count;
                            state_next = crc_pkg::ST_MUL1;
                        end
                        default: ;
                    endcase
                end else if (miss) begin
                    nf_next    = 1'b1;
                    state_next = crc_pkg::ST_OUT;
                end
            end
            crc_pkg::ST_MUL1: begin
                prod_next = product[crc_pkg::DEN_W-1:0];
                if (qe_reg <= qs_reg || sum == '0) begin
                    ratio_next = crc_pkg::RATIO_MAX;
                    state_next = crc_pkg::ST_OUT;
                end else begin
                    state_next = crc_pkg::ST_MUL2;
                end
            end
            crc_pkg::ST_MUL2: begin
                num_next   = {prod_reg[42:0], 16'd0};
                prod_next  = product[crc_pkg::DEN_W-1:0];
                state_next = crc_pkg::ST_DIVGO;
            end
            crc_pkg::ST_DIVGO: begin
                div_start  = 1'b1;
                state_next = crc_pkg::ST_DIVW;
            end
            crc_pkg::ST_DIVW: begin
                if (div_stat.done) begin
                    ratio_next = r_q;
                    keep_next  = (rz > 25'd32768 + thz && rz + thz < 25'd65536)
                                 || (rz > thz && rz + thz < 25'd32768);
                    state_next = crc_pkg::ST_OUT;
                end
            end
            crc_pkg::ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {sc_reg, qe_reg, qs_reg, ratio_reg, nf_reg, keep_reg};
                    state_next   = crc_pkg::ST_IDLE;
                end
            end
            default: state_next = crc_pkg::ST_IDLE;
        endcase
    end

    crc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (num_reg),
        .divisor  (prod_reg),
        .stat     (div_stat),
        .quotient (quotient)
    );

    always_ff @(posedge aclk) begin
        sel_reg    <= sel_next;
        issue_reg  <= issue_next;
        run_reg    <= run_next;
        key_s_reg  <= key_s_next;
        key_e_reg  <= key_e_next;
        qs_reg     <= qs_next;
        qe_reg     <= qe_next;
        sc_reg     <= sc_next;
        del_reg    <= del_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
        prod_reg   <= prod_next;
        num_reg    <= num_next;
        keep_reg   <= keep_next;
        nf_reg     <= nf_next;
        ratio_reg  <= ratio_next;
        m_data_reg <= m_data_next;
        if (!aresetn) begin
            state_reg   <= crc_pkg::ST_IDLE;
            held_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            th_reg      <= crc_pkg::TH_RESET;
            f_reg       <= crc_pkg::FLANK_RESET;
        end else begin
            state_reg   <= state_next;
            held_reg    <= held_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we && cfg_index == crc_pkg::CFG_THRESHOLD) begin
                th_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == crc_pkg::CFG_FLANK) begin
                f_reg <= cfg_data[crc_pkg::FLANK_W-1:0];
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `CRC_ASSERT(a_held_bound, aclk, aresetn, held_reg <= crc_pkg::HELD_MAX)
    `CRC_ASSERT(a_clear_empties, aclk, aresetn, (accept && s_tuser == crc_pkg::CMD_CLEAR) |=> (held_reg == '0))
    `CRC_ASSERT(a_result_from_out, aclk, aresetn, $rose(m_valid_reg) |-> $past(state_reg == crc_pkg::ST_OUT))
    `CRC_ASSERT(a_div_only_waiting, aclk, aresetn, div_stat.busy |-> (state_reg == crc_pkg::ST_DIVW))

endmodule
